FILE: rtl/afd_pkg.sv
// Shared constants and types for the delimited frame extractor.
package afd_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 64;
  localparam int unsigned MAX_BYTES        = 64;
  localparam int unsigned MAX_IDX_W        = $clog2(MAX_BYTES);
  localparam int unsigned MAX_LEN_W        = $clog2(MAX_BYTES + 1);
  localparam int unsigned NUM_BANKS        = 2;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [7:0] START_MARK = 8'h24;
  localparam logic [7:0] END_MARK   = 8'h23;

  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [MAX_IDX_W-1:0] idx;
    logic [7:0]           data;
  } store_wr_t;

  typedef struct packed {
    logic                 bank;
    logic [MAX_LEN_W-1:0] len;
  } frame_desc_t;

endpackage

FILE: rtl/afd_if.sv
// Valid/ready channel interfaces for received bytes and frame bytes.
interface afd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

FILE: rtl/afd_front.sv
// Front end: tracks fill count and start flag, writes frame bytes, posts finished frames.
module afd_front #(
  parameter int unsigned BUFFER_BYTES = afd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  afd_rx_if.sink                rx,
  output afd_pkg::store_wr_t    store_wr,
  output afd_pkg::frame_desc_t  push_desc,
  output logic                  push_valid,
  input  logic                  push_ready,
  input  logic                  release_bank
);
  import afd_pkg::*;

  localparam int unsigned LEN_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(BUFFER_BYTES);
  localparam logic [LEN_W-1:0] CAP = LEN_W'(BUFFER_BYTES);
  localparam logic [1:0] BANKS_BUSY = 2'(NUM_BANKS);

  logic [LEN_W-1:0] fill_count, fill_count_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] fc0, fl0, fl_inc;
  logic             started, started_next, st0;
  logic             bank, bank_next;
  logic [1:0]       pending, pending_next;
  logic             accept, is_start, is_end, clr;

  assign rx.ready = (pending != BANKS_BUSY) && push_ready;
  assign accept   = rx.valid && rx.ready;
  assign is_start = (rx.rx_byte == START_MARK);
  assign is_end   = (rx.rx_byte == END_MARK);
  assign clr      = (fill_count >= CAP);
  assign fc0      = clr ? '0 : fill_count;
  assign fl0      = clr ? '0 : frame_length;
  assign st0      = clr ? 1'b0 : started;
  assign fl_inc   = fl0 + LEN_W'(1);

  always_comb begin
    fill_count_next   = fill_count;
    frame_length_next = frame_length;
    started_next      = started;
    bank_next         = bank;
    store_wr          = '0;
    push_valid        = 1'b0;
    push_desc.bank    = bank;
    push_desc.len     = MAX_LEN_W'(fl_inc);
    if (accept) begin
      fill_count_next   = fc0 + LEN_W'(1);
      frame_length_next = fl0;
      started_next      = st0;
      store_wr.bank     = bank;
      store_wr.data     = rx.rx_byte;
      if (!st0) begin
        if (is_start) begin
          started_next      = 1'b1;
          frame_length_next = LEN_W'(1);
          store_wr.en       = 1'b1;
          store_wr.idx      = '0;
        end
      end else begin
        store_wr.en  = 1'b1;
        store_wr.idx = MAX_IDX_W'(fl0[IDX_W-1:0]);
        if (is_end) begin
          push_valid        = 1'b1;
          bank_next         = !bank;
          fill_count_next   = '0;
          frame_length_next = '0;
          started_next      = 1'b0;
        end else if (fl_inc >= CAP) begin
          fill_count_next   = '0;
          frame_length_next = '0;
          started_next      = 1'b0;
        end else begin
          frame_length_next = fl_inc;
        end
      end
    end
  end

  always_comb begin
    unique case ({push_valid, release_bank})
      2'b10:   pending_next = pending + 2'd1;
      2'b01:   pending_next = pending - 2'd1;
      default: pending_next = pending;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      frame_length <= '0;
      started      <= 1'b0;
      bank         <= 1'b0;
      pending      <= '0;
    end else begin
      fill_count   <= fill_count_next;
      frame_length <= frame_length_next;
      started      <= started_next;
      bank         <= bank_next;
      pending      <= pending_next;
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= BANKS_BUSY)
    else $error("more frames pending than banks");

  a_length_in_fill: assert property (@(posedge clk) disable iff (rst)
    frame_length <= fill_count)
    else $error("frame length exceeds fill count");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !started |-> frame_length == '0)
    else $error("frame bytes held without a start");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready && pending != BANKS_BUSY)
    else $error("frame posted with no free bank");

endmodule

FILE: rtl/afd_queue.sv
// Short queue of finished-frame descriptors between front and back.
module afd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  afd_pkg::frame_desc_t  push_desc,
  input  logic                  push_valid,
  output logic                  push_ready,
  output afd_pkg::frame_desc_t  pop_desc,
  output logic                  pop_valid,
  input  logic                  pop_ready
);
  import afd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  frame_desc_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_desc   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/afd_back.sv
// Back end: double-banked frame store and the frame dump to the output channel.
module afd_back #(
  parameter int unsigned BUFFER_BYTES = afd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  afd_pkg::store_wr_t    store_wr,
  input  afd_pkg::frame_desc_t  pop_desc,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  output logic                  release_bank,
  afd_frame_if.source           frame
);
  import afd_pkg::*;

  localparam int unsigned LEN_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(BUFFER_BYTES);

  logic [7:0]       mem [NUM_BANKS][BUFFER_BYTES];
  logic             active, rd_bank;
  logic [LEN_W-1:0] rd_len, rd_cnt, cnt_inc;
  logic             rv, rlast;
  logic [7:0]       rdata;
  logic             ov, olast;
  logic [7:0]       obyte;
  logic             adv, issue, last_rd, do_pop;

  assign adv          = !ov || frame.ready;
  assign issue        = active && (!rv || adv);
  assign cnt_inc      = rd_cnt + LEN_W'(1);
  assign last_rd      = (cnt_inc == rd_len);
  assign pop_ready    = !active;
  assign do_pop       = pop_valid && pop_ready;
  assign release_bank = issue && last_rd;

  assign frame.valid      = ov;
  assign frame.frame_byte = obyte;
  assign frame.frame_last = olast;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.bank][store_wr.idx[IDX_W-1:0]] <= store_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[rd_bank][rd_cnt[IDX_W-1:0]];
      rlast <= last_rd;
    end
    if (rv && adv) begin
      obyte <= rdata;
      olast <= rlast;
    end
    if (do_pop) begin
      rd_bank <= pop_desc.bank;
      rd_len  <= pop_desc.len[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd_cnt <= '0;
      rv     <= 1'b0;
      ov     <= 1'b0;
    end else begin
      if (do_pop) begin
        active <= 1'b1;
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= cnt_inc;
        if (last_rd) begin
          active <= 1'b0;
        end
      end
      if (issue) begin
        rv <= 1'b1;
      end else if (adv) begin
        rv <= 1'b0;
      end
      if (adv) begin
        ov <= rv;
      end
    end
  end

  a_cnt_in_frame: assert property (@(posedge clk) disable iff (rst)
    active |-> rd_cnt < rd_len)
    else $error("read index past frame length");

  a_release_ends: assert property (@(posedge clk) disable iff (rst)
    release_bank |=> !active)
    else $error("dump still active after bank release");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (rv && !adv) |=> rv && $stable(rdata) && $stable(rlast))
    else $error("read stage lost an item under stall");

endmodule

FILE: rtl/ascii_frame_delimiter_deframer_top.sv
// Top level of the '$'...'#' delimited frame extractor.
//
// Channels: rx takes one received byte per item; frame gives one item per
// byte of each completed frame, '$' first, with frame_last set on the '#'.
// Bytes before a '$' count toward the buffer fill but produce nothing.
// A frame that does not close within BUFFER_BYTES bytes is dropped.
// Throughput: one received byte per cycle unless rx is held off. Frame bytes
// leave at one per cycle unless frame stalls, idle between frames while the
// next descriptor loads. A closed frame's descriptor goes through the queue;
// its '$' then passes the read stage and output register onto frame. The frame
// store has two banks: one fills while the other is dumped. rx is held off
// only while both banks hold frames not yet read out: when a frame closes
// before the one ahead is read out, as when the receiver stalls frame.
// A stall on frame holds the output item; the read stage behind it holds too.
// Reset (rst, synchronous) empties the buffer, the descriptor queue and the
// output stage; frame store contents are not cleared.
module ascii_frame_delimiter_deframer_top #(
  parameter int unsigned BUFFER_BYTES = afd_pkg::BUFFER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  afd_rx_if.sink       rx,
  afd_frame_if.source  frame
);
  import afd_pkg::*;

  store_wr_t   store_wr;
  frame_desc_t push_desc, pop_desc;
  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  logic        release_bank;

  afd_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .store_wr     (store_wr),
    .push_desc    (push_desc),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .release_bank (release_bank)
  );

  afd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_desc  (push_desc),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_desc   (pop_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  afd_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .store_wr     (store_wr),
    .pop_desc     (pop_desc),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .release_bank (release_bank),
    .frame        (frame)
  );

endmodule
